// File: rtl/core/x86mov_pkg.sv
// Package for the 8086 MOV decoder: result type, form codes and the opcode
// decode functions of the byte collector; interfaces and checker use the type.
// Depends on nothing.
package x86mov_pkg;

    localparam logic [2:0] KIND_RMREG   = 3'd0;
    localparam logic [2:0] KIND_IMMRM   = 3'd1;
    localparam logic [2:0] KIND_IMMREG  = 3'd2;
    localparam logic [2:0] KIND_MEMACC  = 3'd3;
    localparam logic [2:0] KIND_RMSEG   = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN = 3'd5;

    localparam logic [1:0] MOD_MEM0  = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT = 3'd6;

    typedef struct packed {
        logic [2:0]  op_kind;
        logic        to_register;
        logic        wide;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
    } t_result;

    function automatic logic [2:0] kind_of(input logic [7:0] op);
        logic [2:0] kind;
        case (op) inside
            [8'h88:8'h8B]:  kind = KIND_RMREG;
            8'hC6, 8'hC7:   kind = KIND_IMMRM;
            [8'hB0:8'hBF]:  kind = KIND_IMMREG;
            [8'hA0:8'hA3]:  kind = KIND_MEMACC;
            8'h8C, 8'h8E:   kind = KIND_RMSEG;
            default:        kind = KIND_UNKNOWN;
        endcase
        return kind;
    endfunction

    function automatic logic has_modrm(input logic [2:0] kind);
        return (kind == KIND_RMREG) || (kind == KIND_IMMRM) || (kind == KIND_RMSEG);
    endfunction

    function automatic logic [1:0] disp_len(input logic [2:0] kind, input logic [7:0] modrm);
        logic [1:0] len;
        len = 2'd0;
        if (kind == KIND_MEMACC) begin
            len = 2'd2;
        end else if (has_modrm(kind)) begin
            if (modrm[7:6] == MOD_DISP8) begin
                len = 2'd1;
            end else if (modrm[7:6] == MOD_DISP16) begin
                len = 2'd2;
            end else if (modrm[7:6] == MOD_MEM0 && modrm[2:0] == RM_DIRECT) begin
                len = 2'd2;
            end
        end
        return len;
    endfunction

    function automatic logic [1:0] imm_len(input logic [2:0] kind, input logic [7:0] op);
        logic [1:0] len;
        len = 2'd0;
        if (kind == KIND_IMMRM) begin
            len = op[0] ? 2'd2 : 2'd1;
        end else if (kind == KIND_IMMREG) begin
            len = op[3] ? 2'd2 : 2'd1;
        end
        return len;
    endfunction

    function automatic t_result make_result(
        input logic [2:0]  kind,
        input logic [7:0]  op,
        input logic [7:0]  modrm,
        input logic [15:0] disp,
        input logic [15:0] imm,
        input logic [2:0]  len
    );
        t_result res;
        res = '0;
        res.op_kind = kind;
        res.length = len;
        res.displacement = disp;
        res.immediate = imm;
        if (has_modrm(kind)) begin
            res.mode = modrm[7:6];
            res.reg_field = modrm[5:3];
            res.rm_field = modrm[2:0];
            if (modrm[7:6] == MOD_DISP8) begin
                res.displacement = {{8{disp[7]}}, disp[7:0]};
            end
        end
        case (kind)
            KIND_RMREG: begin
                res.to_register = op[1];
                res.wide = op[0];
            end
            KIND_IMMRM: begin
                res.to_register = 1'b0;
                res.wide = op[0];
            end
            KIND_IMMREG: begin
                res.to_register = 1'b1;
                res.wide = op[3];
                res.reg_field = op[2:0];
            end
            KIND_MEMACC: begin
                res.to_register = ~op[1];
                res.wide = op[0];
            end
            KIND_RMSEG: begin
                res.to_register = op[1];
                res.wide = 1'b1;
                res.reg_field = {1'b0, modrm[4:3]};
            end
            default: begin
                res.displacement = '0;
                res.immediate = '0;
            end
        endcase
        if (!res.wide) begin
            res.immediate[15:8] = 8'h00;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/x86mov_if.sv
// Valid/ready channel interfaces: the code byte stream and the decoded result stream.
// Depends on x86mov_pkg.
interface x86mov_byte_if;
    import x86mov_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

interface x86mov_res_if;
    import x86mov_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/x86mov_collect.sv
// Byte collector: holds the opcode, ModR/M, displacement and immediate bytes of the
// instruction in progress and forms the decoded result on its last byte.
// Depends on x86mov_pkg.
module x86mov_collect (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_code_byte,
    output logic                o_res_valid,
    output x86mov_pkg::t_result o_res
);
    import x86mov_pkg::*;

    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_need, n_need;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;

    logic [2:0]  kind;
    logic [2:0]  base;
    logic [2:0]  offs;
    logic [2:0]  offs_imm;
    logic [1:0]  dl;
    logic [1:0]  il;

    assign kind = kind_of((r_cnt == 3'd0) ? i_code_byte : r_op);
    assign base = has_modrm(kind) ? 3'd2 : 3'd1;
    assign dl = disp_len(kind, r_modrm);
    assign il = imm_len(kind, r_op);
    assign offs = r_cnt - base;
    assign offs_imm = offs - {1'b0, dl};

    always_comb begin
        n_cnt = r_cnt;
        n_need = r_need;
        n_op = r_op;
        n_modrm = r_modrm;
        n_disp = r_disp;
        n_imm = r_imm;
        o_res_valid = 1'b0;
        o_res = '0;
        if (i_accept) begin
            if (r_cnt == 3'd0) begin
                n_op = i_code_byte;
                if (kind == KIND_UNKNOWN) begin
                    o_res_valid = 1'b1;
                    o_res = make_result(KIND_UNKNOWN, i_code_byte, 8'h00, 16'h0000,
                                        16'h0000, 3'd1);
                    n_op = 8'h00;
                end else begin
                    n_cnt = 3'd1;
                    if (has_modrm(kind)) begin
                        n_need = 3'd2;
                    end else begin
                        n_need = 3'd1 + {1'b0, disp_len(kind, 8'h00)}
                               + {1'b0, imm_len(kind, i_code_byte)};
                    end
                end
            end else begin
                if (has_modrm(kind) && r_cnt == 3'd1) begin
                    n_modrm = i_code_byte;
                    n_need = 3'd2 + {1'b0, disp_len(kind, i_code_byte)}
                           + {1'b0, imm_len(kind, r_op)};
                end else if (offs < {1'b0, dl}) begin
                    if (offs[0]) begin
                        n_disp[15:8] = r_disp[15:8] | i_code_byte;
                    end else begin
                        n_disp[7:0] = r_disp[7:0] | i_code_byte;
                    end
                end else if (offs_imm < {1'b0, il}) begin
                    if (offs_imm[0]) begin
                        n_imm[15:8] = r_imm[15:8] | i_code_byte;
                    end else begin
                        n_imm[7:0] = r_imm[7:0] | i_code_byte;
                    end
                end
                n_cnt = r_cnt + 3'd1;
                if (n_cnt >= n_need) begin
                    o_res_valid = 1'b1;
                    o_res = make_result(kind, n_op, n_modrm, n_disp, n_imm, n_need);
                    n_cnt = 3'd0;
                    n_need = 3'd0;
                    n_op = 8'h00;
                    n_modrm = 8'h00;
                    n_disp = 16'h0000;
                    n_imm = 16'h0000;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_need <= 3'd0;
            r_op <= 8'h00;
            r_modrm <= 8'h00;
            r_disp <= 16'h0000;
            r_imm <= 16'h0000;
        end else begin
            r_cnt <= n_cnt;
            r_need <= n_need;
            r_op <= n_op;
            r_modrm <= n_modrm;
            r_disp <= n_disp;
            r_imm <= n_imm;
        end
    end

endmodule

// File: rtl/core/x86mov_skid.sv
// Result register with a skid entry, so that the upstream ready is a register output.
// Depends on x86mov_pkg.
module x86mov_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_up_valid,
    input  x86mov_pkg::t_result i_up_data,
    output logic                o_up_ready,
    output logic                o_dn_valid,
    output x86mov_pkg::t_result o_dn_data,
    input  logic                i_dn_ready
);
    import x86mov_pkg::*;

    logic    r_main_vld, n_main_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_main, n_main;
    t_result r_skid, n_skid;

    assign o_up_ready = ~r_skid_vld;
    assign o_dn_valid = r_main_vld;
    assign o_dn_data = r_main;

    always_comb begin
        n_main_vld = r_main_vld;
        n_main = r_main;
        n_skid_vld = r_skid_vld;
        n_skid = r_skid;
        if (i_dn_ready || !r_main_vld) begin
            if (r_skid_vld) begin
                n_main_vld = 1'b1;
                n_main = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_main_vld = i_up_valid;
                n_main = i_up_data;
            end
        end else if (i_up_valid && !r_skid_vld) begin
            n_skid_vld = 1'b1;
            n_skid = i_up_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// File: rtl/core/x86_mov_instruction_decoder.sv
// Top level of the 8086 MOV decoder: byte collector followed by the result register.
// Depends on x86mov_pkg, x86mov_if, x86mov_collect and x86mov_skid.
//
// Usage:
// The input channel i_code carries one machine code byte per item, in stream order.
// The output channel o_result carries one decoded MOV instruction per item: form,
// direction, width, ModR/M fields, displacement, immediate and byte length.
// Bytes that do not complete an instruction produce no item; an unknown opcode
// produces an item of kind unknown with length 1 at once.
// Throughput is one byte per cycle while i_code.ready is high. The result item is
// registered in the result register or skid entry once its last byte is accepted.
// When the receiver stalls, one more result is held in a skid entry; i_code.ready
// drops only once both the result register and the skid entry are full.
// Synchronous reset discards any partly collected instruction and any pending result.
module x86_mov_instruction_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    x86mov_byte_if.sink     i_code,
    x86mov_res_if.source    o_result
);
    import x86mov_pkg::*;

    logic    accept;
    logic    up_ready;
    logic    res_valid;
    t_result res;

    assign i_code.ready = up_ready;
    assign accept = i_code.valid & up_ready;

    x86mov_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_byte (i_code.code_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    x86mov_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (res_valid),
        .i_up_data  (res),
        .o_up_ready (up_ready),
        .o_dn_valid (o_result.valid),
        .o_dn_data  (o_result.data),
        .i_dn_ready (o_result.ready)
    );

endmodule

// File: rtl/core/x86mov_checker.sv
// Port checker for the MOV decoder and the bind that attaches it to the top level.
// Depends on x86mov_pkg and x86_mov_instruction_decoder.
module x86mov_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input x86mov_pkg::t_result i_out_data
);
    import x86mov_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result item dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("Result item changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result item valid after reset.");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && !(i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("Result item appeared without an accepted byte.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("Input stalled while no result item is pending.");

endmodule

bind x86_mov_instruction_decoder x86mov_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_code.valid),
    .i_in_ready  (i_code.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

// File: tb/x86_mov_instruction_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench for the 8086 MOV decoder: directed and random code byte streams go in
// through the byte channel, and every decoded item is checked against a predictor.
// Depends on x86mov_pkg, x86mov_if and x86_mov_instruction_decoder.
module x86_mov_instruction_decoder_tb;
    import x86mov_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int BYTE_TARGET = 550;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTED = 40;

    typedef struct {
        logic [7:0] code;
        bit         drain;
    } t_code_item;

    logic i_clk;
    logic i_rst_n;

    x86mov_byte_if code_if();
    x86mov_res_if  result_if();

    t_code_item code_queue[$];
    t_result    pending_decodes[$];

    logic [2:0]  held_count;
    logic [2:0]  need_count;
    logic [7:0]  held_opcode;
    logic [7:0]  held_modrm;
    logic [15:0] held_disp;
    logic [15:0] held_imm;

    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned decodes_checked;
    int unsigned cycle_count;
    int unsigned pause_left;
    int unsigned stall_left;
    int unsigned form_seen[8];
    bit          steady_in;
    bit          steady_out;

    logic [7:0] opening_stream [0:28] = '{
        8'hFF,
        8'h89, 8'hC8,
        8'h8B, 8'h46, 8'h80,
        8'h8A, 8'h06, 8'h34, 8'h12,
        8'hC7, 8'h86, 8'hFF, 8'hFF, 8'h00, 8'h80,
        8'hC6, 8'h38, 8'hAB,
        8'hB0, 8'h00,
        8'hBF, 8'hFF, 8'hFF,
        8'hA2, 8'hFF, 8'hFF,
        8'h8E, 8'hE8
    };

    x86_mov_instruction_decoder DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (code_if),
        .o_result (result_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [2:0] form_of(input logic [7:0] op);
        logic [2:0] kind;
        kind = KIND_UNKNOWN;
        if (op >= 8'h88 && op <= 8'h8B) begin
            kind = KIND_RMREG;
        end else if (op == 8'hC6 || op == 8'hC7) begin
            kind = KIND_IMMRM;
        end else if (op[7:4] == 4'hB) begin
            kind = KIND_IMMREG;
        end else if (op >= 8'hA0 && op <= 8'hA3) begin
            kind = KIND_MEMACC;
        end else if (op == 8'h8C || op == 8'h8E) begin
            kind = KIND_RMSEG;
        end
        return kind;
    endfunction

    function automatic bit takes_modrm(input logic [2:0] kind);
        return (kind == KIND_RMREG) || (kind == KIND_IMMRM) || (kind == KIND_RMSEG);
    endfunction

    function automatic int disp_bytes(input logic [2:0] kind, input logic [7:0] modrm);
        int n;
        n = 0;
        if (kind == KIND_MEMACC) begin
            n = 2;
        end else if (takes_modrm(kind)) begin
            if (modrm[7:6] == MOD_DISP8) begin
                n = 1;
            end else if (modrm[7:6] == MOD_DISP16) begin
                n = 2;
            end else if (modrm[7:6] == MOD_MEM0 && modrm[2:0] == RM_DIRECT) begin
                n = 2;
            end
        end
        return n;
    endfunction

    function automatic int imm_bytes(input logic [2:0] kind, input logic [7:0] op);
        int n;
        n = 0;
        if (kind == KIND_IMMRM) begin
            n = op[0] ? 2 : 1;
        end else if (kind == KIND_IMMREG) begin
            n = op[3] ? 2 : 1;
        end
        return n;
    endfunction

    function automatic t_result decoded_fields(
        input logic [2:0]  kind,
        input logic [7:0]  op,
        input logic [7:0]  modrm,
        input logic [15:0] disp,
        input logic [15:0] imm,
        input logic [2:0]  len
    );
        t_result fields;
        fields = '0;
        fields.op_kind = kind;
        fields.length = len;
        fields.displacement = disp;
        fields.immediate = imm;
        if (takes_modrm(kind)) begin
            fields.mode = modrm[7:6];
            fields.reg_field = modrm[5:3];
            fields.rm_field = modrm[2:0];
            if (modrm[7:6] == MOD_DISP8) begin
                fields.displacement = {{8{disp[7]}}, disp[7:0]};
            end
        end
        case (kind)
            KIND_RMREG: begin
                fields.to_register = op[1];
                fields.wide = op[0];
            end
            KIND_IMMRM: begin
                fields.wide = op[0];
            end
            KIND_IMMREG: begin
                fields.to_register = 1'b1;
                fields.wide = op[3];
                fields.reg_field = op[2:0];
            end
            KIND_MEMACC: begin
                fields.to_register = !op[1];
                fields.wide = op[0];
            end
            KIND_RMSEG: begin
                fields.to_register = op[1];
                fields.wide = 1'b1;
                fields.reg_field = {1'b0, modrm[4:3]};
            end
            default: begin
                fields.displacement = '0;
                fields.immediate = '0;
            end
        endcase
        if (!fields.wide) begin
            fields.immediate[15:8] = 8'h00;
        end
        return fields;
    endfunction

    task automatic clear_decode_state();
        held_count = '0;
        need_count = '0;
        held_opcode = '0;
        held_modrm = '0;
        held_disp = '0;
        held_imm = '0;
    endtask

    task automatic absorb_code_byte(input logic [7:0] b);
        logic [2:0] kind;
        int pos;
        int base;
        int off;
        int dl;
        int il;
        if (held_count == 0) begin
            held_opcode = b;
            kind = form_of(b);
            if (kind == KIND_UNKNOWN) begin
                pending_decodes.push_back(decoded_fields(kind, b, 8'h00, 16'h0000,
                                                         16'h0000, 3'd1));
                clear_decode_state();
            end else begin
                held_count = 3'd1;
                need_count = takes_modrm(kind) ? 3'd2
                    : 3'(1 + disp_bytes(kind, 8'h00) + imm_bytes(kind, b));
            end
        end else begin
            kind = form_of(held_opcode);
            pos = held_count;
            base = takes_modrm(kind) ? 2 : 1;
            if (takes_modrm(kind) && pos == 1) begin
                held_modrm = b;
                need_count = 3'(2 + disp_bytes(kind, b) + imm_bytes(kind, held_opcode));
            end else begin
                off = pos - base;
                dl = disp_bytes(kind, held_modrm);
                il = imm_bytes(kind, held_opcode);
                if (off < dl) begin
                    held_disp = held_disp | (16'(b) << (8 * (off % 2)));
                end else if (off - dl < il) begin
                    held_imm = held_imm | (16'(b) << (8 * ((off - dl) % 2)));
                end
            end
            held_count = held_count + 3'd1;
            if (held_count >= need_count) begin
                pending_decodes.push_back(decoded_fields(kind, held_opcode, held_modrm,
                                                         held_disp, held_imm, need_count));
                clear_decode_state();
            end
        end
    endtask

    task automatic push_code(input logic [7:0] b, input bit drain);
        t_code_item entry;
        entry.code = b;
        entry.drain = drain;
        code_queue.push_back(entry);
    endtask

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            2: b = 8'h80;
            3: b = 8'h7F;
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    task automatic queue_instruction(input logic [2:0] kind, input bit drain);
        logic [7:0] op;
        logic [7:0] modrm;
        int n;
        case (kind)
            KIND_RMREG: op = 8'h88 | 8'($urandom_range(0, 3));
            KIND_IMMRM: op = 8'hC6 | 8'($urandom_range(0, 1));
            KIND_IMMREG: op = 8'hB0 | 8'($urandom_range(0, 15));
            KIND_MEMACC: op = 8'hA0 | 8'($urandom_range(0, 3));
            KIND_RMSEG: op = $urandom_range(0, 1) ? 8'h8E : 8'h8C;
            default: begin
                op = 8'($urandom);
                while (form_of(op) != KIND_UNKNOWN) begin
                    op = 8'($urandom);
                end
            end
        endcase
        push_code(op, drain);
        modrm = 8'h00;
        if (takes_modrm(kind)) begin
            modrm = 8'($urandom);
            if ($urandom_range(0, 5) == 0) begin
                modrm = {MOD_MEM0, modrm[5:3], RM_DIRECT};
            end
            push_code(modrm, 1'b0);
        end
        n = disp_bytes(kind, modrm) + imm_bytes(kind, op);
        repeat (n) push_code(data_byte(), 1'b0);
    endtask

    function automatic int unsigned pick_pause(input bit steady);
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!steady) begin
            if (r >= 95) begin
                n = $urandom_range(8, 30);
            end else if (r >= 60) begin
                n = $urandom_range(1, 3);
            end
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("ERROR at cycle %0d: %s", cycle_count, what);
        end
    endtask

    task automatic check_decode(input t_result want, input t_result got);
        string tag;
        tag = $sformatf("decode %0d", decodes_checked);
        if (got.op_kind !== want.op_kind)
            report_mismatch($sformatf("%s op_kind %0d, expected %0d", tag,
                                      got.op_kind, want.op_kind));
        if (got.to_register !== want.to_register)
            report_mismatch($sformatf("%s to_register %0d, expected %0d", tag,
                                      got.to_register, want.to_register));
        if (got.wide !== want.wide)
            report_mismatch($sformatf("%s wide %0d, expected %0d", tag,
                                      got.wide, want.wide));
        if (got.mode !== want.mode)
            report_mismatch($sformatf("%s mode %0d, expected %0d", tag,
                                      got.mode, want.mode));
        if (got.reg_field !== want.reg_field)
            report_mismatch($sformatf("%s reg_field %0d, expected %0d", tag,
                                      got.reg_field, want.reg_field));
        if (got.rm_field !== want.rm_field)
            report_mismatch($sformatf("%s rm_field %0d, expected %0d", tag,
                                      got.rm_field, want.rm_field));
        if (got.displacement !== want.displacement)
            report_mismatch($sformatf("%s displacement %h, expected %h", tag,
                                      got.displacement, want.displacement));
        if (got.immediate !== want.immediate)
            report_mismatch($sformatf("%s immediate %h, expected %h", tag,
                                      got.immediate, want.immediate));
        if (got.length !== want.length)
            report_mismatch($sformatf("%s length %0d, expected %0d", tag,
                                      got.length, want.length));
        form_seen[want.op_kind]++;
        decodes_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            code_if.valid <= 1'b0;
            code_if.code_byte <= 8'h00;
        end else begin
            if (code_if.valid && code_if.ready) begin
                absorb_code_byte(code_if.code_byte);
                bytes_sent++;
            end
            if (!code_if.valid || code_if.ready) begin
                if (pause_left > 0) begin
                    pause_left--;
                    code_if.valid <= 1'b0;
                end else if (code_queue.size() > 0 &&
                             !(code_queue[0].drain && pending_decodes.size() > 0)) begin
                    code_if.valid <= 1'b1;
                    code_if.code_byte <= code_queue[0].code;
                    void'(code_queue.pop_front());
                    if ($urandom_range(0, 39) == 0) begin
                        steady_in = !steady_in;
                    end
                    pause_left = pick_pause(steady_in);
                end else begin
                    code_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (pending_decodes.size() == 0) begin
                    report_mismatch("result item arrived with nothing expected");
                end else begin
                    check_decode(pending_decodes.pop_front(), result_if.data);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    steady_out = !steady_out;
                end
                stall_left = pick_pause(steady_out);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int unsigned round;
        bit drain;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        code_if.valid = 1'b0;
        code_if.code_byte = 8'h00;
        result_if.ready = 1'b0;
        clear_decode_state();

        foreach (opening_stream[i]) begin
            push_code(opening_stream[i], 1'b0);
        end
        round = 0;
        while (code_queue.size() < $size(opening_stream) + BYTE_TARGET) begin
            // Now and then hold the stream until every decode so far has come out.
            drain = (round % 80 == 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_code(8'($urandom), drain);
            end else if (r < 16) begin
                queue_instruction(KIND_UNKNOWN, drain);
            end else begin
                queue_instruction(3'($urandom_range(0, 4)), drain);
            end
            round++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (code_queue.size() > 0 || code_if.valid !== 1'b0) begin
            @(posedge i_clk);
        end
        while (pending_decodes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Fed %0d code bytes and checked %0d decoded items.", bytes_sent,
                 decodes_checked);
        $display("Forms: rm-reg %0d, imm-rm %0d, imm-reg %0d, mem-acc %0d, rm-seg %0d, unknown %0d.",
                 form_seen[KIND_RMREG], form_seen[KIND_IMMRM], form_seen[KIND_IMMREG],
                 form_seen[KIND_MEMACC], form_seen[KIND_RMSEG], form_seen[KIND_UNKNOWN]);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/x86mov_pkg.sv
rtl/core/x86mov_if.sv
rtl/core/x86mov_collect.sv
rtl/core/x86mov_skid.sv
rtl/core/x86_mov_instruction_decoder.sv
rtl/core/x86mov_checker.sv
tb/x86_mov_instruction_decoder_tb.sv
